// ----- src/sts_pkg.sv -----
// Shared types, constants and scan functions for the SQL token scanner.
// No dependencies; every other file in src imports this package.
package sts_pkg;

  localparam int KEYWORD_CHARS = 7;
  localparam int POSITION_BITS = 16;
  localparam int WLEN_BITS = $clog2(KEYWORD_CHARS + 2);
  localparam int WIDX_BITS = $clog2(KEYWORD_CHARS);
  localparam int KEYWORD_COUNT = 29;
  localparam int MAX_RESULTS = 3;
  // Result queue depth; must be a power of two and at least MAX_RESULTS + 1.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [0:KEYWORD_CHARS-1][7:0] word_buf_t;

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_SIGN, M_INT, M_DOT, M_FRAC,
    M_STR, M_STRQ, M_BANG, M_LT, M_GT
  } mode_t;

  // Token kinds.
  localparam logic [5:0] TK_EOF    = 6'd0;
  localparam logic [5:0] TK_IDENT  = 6'd1;
  localparam logic [5:0] TK_KW0    = 6'd2;
  localparam logic [5:0] TK_INT    = 6'd31;
  localparam logic [5:0] TK_DOUBLE = 6'd32;
  localparam logic [5:0] TK_STRING = 6'd33;
  localparam logic [5:0] TK_LPAREN = 6'd34;
  localparam logic [5:0] TK_RPAREN = 6'd35;
  localparam logic [5:0] TK_COMMA  = 6'd36;
  localparam logic [5:0] TK_SEMI   = 6'd37;
  localparam logic [5:0] TK_STAR   = 6'd38;
  localparam logic [5:0] TK_EQ     = 6'd39;
  localparam logic [5:0] TK_NE     = 6'd40;
  localparam logic [5:0] TK_LT     = 6'd41;
  localparam logic [5:0] TK_LE     = 6'd42;
  localparam logic [5:0] TK_GT     = 6'd43;
  localparam logic [5:0] TK_GE     = 6'd44;
  localparam logic [5:0] TK_ERROR  = 6'd45;

  // Error codes.
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_CHAR   = 3'd1;
  localparam logic [2:0] ERR_BANG   = 3'd2;
  localparam logic [2:0] ERR_STRING = 3'd3;
  localparam logic [2:0] ERR_NUMBER = 3'd4;

  typedef struct packed {
    logic [5:0] kind;
    logic [2:0] code;
    pos_t       off;
    pos_t       line;
    pos_t       col;
    pos_t       span;
    logic       last;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] r;
    logic [1:0]                n;
  } result_set_t;

  typedef struct packed {
    mode_t                mode;
    word_buf_t            wbuf;
    logic [WLEN_BITS-1:0] wlen;
    pos_t                 off;
    pos_t                 line;
    pos_t                 col;
    pos_t                 org_off;
    pos_t                 org_line;
    pos_t                 org_col;
    pos_t                 span;
    logic                 err;
  } scan_state_t;

  function automatic scan_state_t reset_state();
    scan_state_t s;
    s = '0;
    s.mode = M_IDLE;
    s.line = pos_t'(1);
    s.col = pos_t'(1);
    return s;
  endfunction

  // Keyword table: length and right-justified upper-case text.
  function automatic logic [WLEN_BITS+8*KEYWORD_CHARS-1:0] kw_entry(input int i);
    logic [3:0] ln;
    logic [55:0] t;
    case (i)
      0: begin ln = 4'd6; t = 56'("CREATE"); end
      1: begin ln = 4'd5; t = 56'("TABLE"); end
      2: begin ln = 4'd6; t = 56'("INSERT"); end
      3: begin ln = 4'd4; t = 56'("INTO"); end
      4: begin ln = 4'd6; t = 56'("VALUES"); end
      5: begin ln = 4'd6; t = 56'("SELECT"); end
      6: begin ln = 4'd4; t = 56'("FROM"); end
      7: begin ln = 4'd5; t = 56'("WHERE"); end
      8: begin ln = 4'd3; t = 56'("KEY"); end
      9: begin ln = 4'd7; t = 56'("PRIMARY"); end
      10: begin ln = 4'd4; t = 56'("NULL"); end
      11: begin ln = 4'd3; t = 56'("NOT"); end
      12: begin ln = 4'd3; t = 56'("AND"); end
      13: begin ln = 4'd2; t = 56'("OR"); end
      14: begin ln = 4'd2; t = 56'("IS"); end
      15: begin ln = 4'd6; t = 56'("STRING"); end
      16: begin ln = 4'd5; t = 56'("INT64"); end
      17: begin ln = 4'd6; t = 56'("DOUBLE"); end
      18: begin ln = 4'd5; t = 56'("COUNT"); end
      19: begin ln = 4'd3; t = 56'("SUM"); end
      20: begin ln = 4'd3; t = 56'("AVG"); end
      21: begin ln = 4'd3; t = 56'("MIN"); end
      22: begin ln = 4'd3; t = 56'("MAX"); end
      23: begin ln = 4'd5; t = 56'("GROUP"); end
      24: begin ln = 4'd2; t = 56'("BY"); end
      25: begin ln = 4'd5; t = 56'("ORDER"); end
      26: begin ln = 4'd5; t = 56'("LIMIT"); end
      27: begin ln = 4'd3; t = 56'("ASC"); end
      28: begin ln = 4'd4; t = 56'("DESC"); end
      default: begin ln = 4'd0; t = '0; end
    endcase
    return {WLEN_BITS'(ln), (8*KEYWORD_CHARS)'(t)};
  endfunction

  // Parallel compare of the held word against every keyword.
  function automatic logic [5:0] word_kind(input word_buf_t wbuf,
                                           input logic [WLEN_BITS-1:0] wlen);
    logic [5:0] k;
    logic [WLEN_BITS+8*KEYWORD_CHARS-1:0] e;
    logic [WLEN_BITS-1:0] ln;
    logic [8*KEYWORD_CHARS-1:0] lit;
    k = TK_IDENT;
    for (int i = 0; i < KEYWORD_COUNT; i++) begin
      e = kw_entry(i);
      ln = e[WLEN_BITS+8*KEYWORD_CHARS-1 -: WLEN_BITS];
      lit = e[8*KEYWORD_CHARS-1:0] << (8 * (KEYWORD_CHARS - int'(ln)));
      if (ln == wlen && lit == wbuf) begin
        k = TK_KW0 + 6'(i);
      end
    end
    return k;
  endfunction

  function automatic pos_t sat_inc(input pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void put(inout result_set_t rs, input logic [5:0] kind,
                              input logic [2:0] code, input pos_t off,
                              input pos_t line, input pos_t col, input pos_t span);
    if (rs.n < 2'(MAX_RESULTS)) begin
      rs.r[rs.n] = '{kind: kind, code: code, off: off, line: line, col: col,
                     span: span, last: 1'b0};
      rs.n = rs.n + 2'd1;
    end
  endfunction

  function automatic void advance(inout scan_state_t s, input logic [7:0] c);
    s.off = sat_inc(s.off);
    if (c == 8'h0a) begin
      s.line = sat_inc(s.line);
      s.col = pos_t'(1);
    end else begin
      s.col = sat_inc(s.col);
    end
  endfunction

  function automatic void take(inout scan_state_t s, input logic [7:0] c);
    advance(s, c);
    s.span = sat_inc(s.span);
  endfunction

  function automatic void mark_origin(inout scan_state_t s);
    s.org_off = s.off;
    s.org_line = s.line;
    s.org_col = s.col;
    s.span = '0;
  endfunction

  function automatic void start_tok(inout scan_state_t s, input logic [7:0] c,
                                    input mode_t m);
    mark_origin(s);
    take(s, c);
    s.mode = m;
  endfunction

  function automatic void finish(inout scan_state_t s, inout result_set_t rs,
                                 input logic [5:0] kind);
    put(rs, kind, ERR_NONE, s.org_off, s.org_line, s.org_col, s.span);
    s.mode = M_IDLE;
  endfunction

  function automatic void fail(inout scan_state_t s, inout result_set_t rs,
                               input logic [2:0] code);
    put(rs, TK_ERROR, code, s.org_off, s.org_line, s.org_col, '0);
    s.err = 1'b1;
    s.mode = M_IDLE;
  endfunction

  function automatic void add_word(inout scan_state_t s, input logic [7:0] c);
    if (s.wlen < WLEN_BITS'(KEYWORD_CHARS)) begin
      s.wbuf[s.wlen[WIDX_BITS-1:0]] = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    end
    if (s.wlen <= WLEN_BITS'(KEYWORD_CHARS)) begin
      s.wlen = s.wlen + WLEN_BITS'(1);
    end
  endfunction

  function automatic void scan_idle(inout scan_state_t s, inout result_set_t rs,
                                    input logic [7:0] c);
    logic [5:0] k;
    k = TK_EOF;
    if (c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d) begin
      advance(s, c);
    end else if (is_alpha(c) || c == "_") begin
      s.wbuf = '0;
      s.wlen = '0;
      add_word(s, c);
      start_tok(s, c, M_WORD);
    end else if (is_digit(c)) begin
      start_tok(s, c, M_INT);
    end else begin
      case (c)
        "-": start_tok(s, c, M_SIGN);
        "'": start_tok(s, c, M_STR);
        "!": start_tok(s, c, M_BANG);
        "<": start_tok(s, c, M_LT);
        ">": start_tok(s, c, M_GT);
        "(": k = TK_LPAREN;
        ")": k = TK_RPAREN;
        ",": k = TK_COMMA;
        ";": k = TK_SEMI;
        "*": k = TK_STAR;
        "=": k = TK_EQ;
        default: begin
          mark_origin(s);
          fail(s, rs, ERR_CHAR);
        end
      endcase
      if (k != TK_EOF) begin
        start_tok(s, c, M_IDLE);
        finish(s, rs, k);
      end
    end
  endfunction

  // Returns 0 when the byte closed the pending token and must be scanned again.
  function automatic logic scan_char(inout scan_state_t s, inout result_set_t rs,
                                     input logic [7:0] c);
    logic done;
    done = 1'b1;
    case (s.mode)
      M_IDLE: scan_idle(s, rs, c);
      M_WORD: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          add_word(s, c);
          take(s, c);
        end else begin
          finish(s, rs, word_kind(s.wbuf, s.wlen));
          done = 1'b0;
        end
      end
      M_SIGN: begin
        if (is_digit(c)) begin
          take(s, c);
          s.mode = M_INT;
        end else begin
          fail(s, rs, ERR_CHAR);
        end
      end
      M_INT: begin
        if (is_digit(c)) begin
          take(s, c);
        end else if (c == ".") begin
          take(s, c);
          s.mode = M_DOT;
        end else begin
          finish(s, rs, TK_INT);
          done = 1'b0;
        end
      end
      M_DOT: begin
        if (is_digit(c)) begin
          take(s, c);
          s.mode = M_FRAC;
        end else begin
          fail(s, rs, ERR_NUMBER);
        end
      end
      M_FRAC: begin
        if (is_digit(c)) begin
          take(s, c);
        end else begin
          finish(s, rs, TK_DOUBLE);
          done = 1'b0;
        end
      end
      M_STR: begin
        take(s, c);
        if (c == "'") s.mode = M_STRQ;
      end
      M_STRQ: begin
        if (c == "'") begin
          take(s, c);
          s.mode = M_STR;
        end else begin
          finish(s, rs, TK_STRING);
          done = 1'b0;
        end
      end
      M_BANG: begin
        if (c == "=") begin
          take(s, c);
          finish(s, rs, TK_NE);
        end else begin
          fail(s, rs, ERR_BANG);
        end
      end
      M_LT: begin
        if (c == "=") begin
          take(s, c);
          finish(s, rs, TK_LE);
        end else begin
          finish(s, rs, TK_LT);
          done = 1'b0;
        end
      end
      M_GT: begin
        if (c == "=") begin
          take(s, c);
          finish(s, rs, TK_GE);
        end else begin
          finish(s, rs, TK_GT);
          done = 1'b0;
        end
      end
      default: begin
        s.mode = M_IDLE;
        done = 1'b0;
      end
    endcase
    return done;
  endfunction

  // Close whatever token is pending at end of input.
  function automatic void flush(inout scan_state_t s, inout result_set_t rs);
    case (s.mode)
      M_WORD: finish(s, rs, word_kind(s.wbuf, s.wlen));
      M_SIGN: fail(s, rs, ERR_CHAR);
      M_INT: finish(s, rs, TK_INT);
      M_DOT: fail(s, rs, ERR_NUMBER);
      M_FRAC: finish(s, rs, TK_DOUBLE);
      M_STR: fail(s, rs, ERR_STRING);
      M_STRQ: finish(s, rs, TK_STRING);
      M_BANG: fail(s, rs, ERR_BANG);
      M_LT: finish(s, rs, TK_LT);
      M_GT: finish(s, rs, TK_GT);
      default: ;
    endcase
  endfunction

endpackage

// ----- src/sql_token_scanner.sv -----
// Streaming SQL tokenizer: one byte per request in, token descriptors out.
// A request whose byte produces at most one descriptor is taken every cycle
// while the receiver takes results; a request producing more (up to 3) holds
// the input while the result queue drains, one descriptor per cycle when the
// receiver is ready. From input acceptance to the first descriptor the path is:
// input register, scan logic into the result queue, queue head drives the outputs.
module sql_token_scanner (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   character,
  input  logic                         char_present,
  input  logic                         end_of_input,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [5:0]                   token_kind,
  output logic [2:0]                   error_code,
  output logic [sts_pkg::POSITION_BITS-1:0] start_offset,
  output logic [sts_pkg::POSITION_BITS-1:0] start_line,
  output logic [sts_pkg::POSITION_BITS-1:0] start_column,
  output logic [sts_pkg::POSITION_BITS-1:0] span_length,
  output logic                         last_of_run
);
  import sts_pkg::*;

  logic       in_full;
  logic [7:0] in_char;
  logic       in_present;
  logic       in_end;
  logic       consume;
  logic       room;
  result_set_t rs;
  result_t    head;

  assign consume = in_full && room;
  assign in_ready = !in_full || consume;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char <= character;
      in_present <= char_present;
      in_end <= end_of_input;
    end
  end

  sts_scan_core u_core (
    .clk          (clk),
    .rst          (rst),
    .consume      (consume),
    .character    (in_char),
    .char_present (in_present),
    .end_of_input (in_end),
    .rs           (rs)
  );

  sts_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (consume),
    .push_set   (rs),
    .pop        (out_valid && out_ready),
    .room       (room),
    .head_valid (out_valid),
    .head       (head)
  );

  assign token_kind = head.kind;
  assign error_code = head.code;
  assign start_offset = head.off;
  assign start_line = head.line;
  assign start_column = head.col;
  assign span_length = head.span;
  assign last_of_run = head.last;

endmodule

// ----- src/sts_scan_core.sv -----
// Scanner state registers and the per-request next-state and result logic.
// Depends on sts_pkg.
module sts_scan_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                consume,
  input  logic [7:0]          character,
  input  logic                char_present,
  input  logic                end_of_input,
  output sts_pkg::result_set_t rs
);
  import sts_pkg::*;

  scan_state_t st;
  scan_state_t st_next;

  // One request: scan the byte (twice if it closed a token), then end handling.
  always_comb begin
    scan_state_t s;
    result_set_t r;
    s = st;
    r = '0;
    if (char_present && !s.err) begin
      if (!scan_char(s, r, character) && !s.err) begin
        void'(scan_char(s, r, character));
      end
    end
    if (end_of_input) begin
      if (!s.err) flush(s, r);
      if (!s.err) put(r, TK_EOF, ERR_NONE, s.off, s.line, s.col, '0);
      s = reset_state();
    end
    if (r.n != 2'd0) begin
      r.r[r.n - 2'd1].last = 1'b1;
    end
    st_next = s;
    rs = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= reset_state();
    end else if (consume) begin
      st <= st_next;
    end
  end

endmodule

// ----- src/sts_result_queue.sv -----
// Small result queue: takes up to three results per cycle, hands out one per pop.
// Depends on sts_pkg.
module sts_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sts_pkg::result_set_t push_set,
  input  logic                 pop,
  output logic                 room,
  output logic                 head_valid,
  output sts_pkg::result_t     head
);
  import sts_pkg::*;

  result_t mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic [QPTR_BITS:0]   count_next;
  logic [1:0]           push_n;

  assign push_n = push ? push_set.n : 2'd0;
  assign count_next = count + (QPTR_BITS+1)'(push_n) - (QPTR_BITS+1)'(pop);
  // Room for a full set of results, judged on the registered count only.
  assign room = count <= (QPTR_BITS+1)'(QUEUE_DEPTH - MAX_RESULTS);
  assign head_valid = count != '0;
  assign head = mem[rd_ptr];

  // Pointer and count registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_BITS'(push_n);
      rd_ptr <= rd_ptr + QPTR_BITS'(pop);
      count <= count_next;
    end
  end

  // Entry writes, one per result of the request.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < push_n) begin
        mem[wr_ptr + QPTR_BITS'(k)] <= push_set.r[k];
      end
    end
  end

endmodule

// ----- src/sts_checker.sv -----
// Port-level checks on the token scanner's result channel, and their binding.
// Depends on sts_pkg and sql_token_scanner.
module sts_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] token_kind,
  input logic [2:0] error_code,
  input logic [sts_pkg::POSITION_BITS-1:0] span_length,
  input logic       last_of_run
);
  import sts_pkg::*;

  // A stalled descriptor stays valid and keeps its kind.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind))
    else $error("result changed while stalled");

  // End of file is always the final result of its request.
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == TK_EOF |-> last_of_run)
    else $error("eof not last of run");

  // Error results carry a code and no span.
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == TK_ERROR |-> error_code != ERR_NONE && span_length == '0)
    else $error("malformed error result");

  // Other results carry no error code.
  a_noerr: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != TK_ERROR |-> error_code == ERR_NONE)
    else $error("error code on a token");

endmodule

bind sql_token_scanner sts_checker u_sts_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .token_kind  (token_kind),
  .error_code  (error_code),
  .span_length (span_length),
  .last_of_run (last_of_run)
);

// ----- bench/tb_top.sv -----
// Self-checking bench for the SQL token scanner: table of directed requests and
// random statements, checked against a behavioral lexer model.
// Depends on src/sts_pkg.sv and src/sql_token_scanner.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sts_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int POS_TOP = 65535;

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  code;
    logic [15:0] off;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] span;
    logic        last;
  } token_t;

  typedef struct {
    byte unsigned ch;
    bit           pres;
    bit           eoi;
    bit           typed;
    token_t       want;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  character = 8'h00;
  logic        char_present = 1'b0;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  token_kind;
  logic [2:0]  error_code;
  logic [15:0] start_offset;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] span_length;
  logic        last_of_run;

  sql_token_scanner i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .character(character), .char_present(char_present), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .token_kind(token_kind), .error_code(error_code),
    .start_offset(start_offset), .start_line(start_line),
    .start_column(start_column), .span_length(span_length),
    .last_of_run(last_of_run)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Lexer state kept by the bench.
  mode_t        lx_mode;
  byte unsigned lx_word[7];
  int           lx_wlen;
  int           lx_off, lx_line, lx_col;
  int           lx_org_off, lx_org_line, lx_org_col, lx_span;
  bit           lx_hold;
  int           lx_nres;
  token_t       lx_first;

  token_t       pending_tokens[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;
  bit           gaps_on = 1'b1;
  int           bytes_sent = 0;
  byte unsigned stmt[$];
  row_t         rows[$];

  string keywords[29] = '{"CREATE", "TABLE", "INSERT", "INTO", "VALUES", "SELECT",
    "FROM", "WHERE", "KEY", "PRIMARY", "NULL", "NOT", "AND", "OR", "IS", "STRING",
    "INT64", "DOUBLE", "COUNT", "SUM", "AVG", "MIN", "MAX", "GROUP", "BY", "ORDER",
    "LIMIT", "ASC", "DESC"};

  function automatic int bump(int v);
    return (v < POS_TOP) ? v + 1 : v;
  endfunction

  function automatic bit is_letter(byte unsigned c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_num(byte unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void lexer_clear();
    lx_mode = M_IDLE;
    foreach (lx_word[i]) lx_word[i] = 8'h00;
    lx_wlen = 0;
    lx_off = 0;
    lx_line = 1;
    lx_col = 1;
    lx_org_off = 0;
    lx_org_line = 0;
    lx_org_col = 0;
    lx_span = 0;
    lx_hold = 1'b0;
  endfunction

  function automatic void emit_token(logic [5:0] kind, logic [2:0] code, int span);
    token_t t;
    t = '{kind: kind, code: code, off: 16'(lx_org_off), line: 16'(lx_org_line),
          col: 16'(lx_org_col), span: 16'(span), last: 1'b0};
    if (lx_nres < MAX_RESULTS) begin
      if (lx_nres == 0) lx_first = t;
      pending_tokens.insert(pending_tokens.size(), t);
      lx_nres++;
    end
  endfunction

  function automatic void step_pos(byte unsigned c);
    lx_off = bump(lx_off);
    if (c == 8'h0a) begin
      lx_line = bump(lx_line);
      lx_col = 1;
    end else begin
      lx_col = bump(lx_col);
    end
  endfunction

  function automatic void consume(byte unsigned c);
    step_pos(c);
    lx_span = bump(lx_span);
  endfunction

  function automatic void open_token(byte unsigned c, mode_t m);
    lx_org_off = lx_off;
    lx_org_line = lx_line;
    lx_org_col = lx_col;
    lx_span = 0;
    consume(c);
    lx_mode = m;
  endfunction

  function automatic void close_token(logic [5:0] kind);
    emit_token(kind, ERR_NONE, lx_span);
    lx_mode = M_IDLE;
  endfunction

  function automatic void raise_error(logic [2:0] code);
    emit_token(TK_ERROR, code, 0);
    lx_hold = 1'b1;
    lx_mode = M_IDLE;
  endfunction

  function automatic logic [5:0] classify_word();
    bit same;
    if (lx_wlen > 7) return TK_IDENT;
    for (int i = 0; i < 29; i++) begin
      same = (keywords[i].len() == lx_wlen);
      for (int j = 0; j < lx_wlen && same; j++)
        if (keywords[i][j] != lx_word[j]) same = 1'b0;
      if (same) return TK_KW0 + 6'(i);
    end
    return TK_IDENT;
  endfunction

  function automatic void append_word(byte unsigned c);
    if (lx_wlen < 7) lx_word[lx_wlen] = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (lx_wlen <= 7) lx_wlen++;
  endfunction

  function automatic void scan_from_idle(byte unsigned c);
    if (c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d) begin
      step_pos(c);
    end else if (is_letter(c) || c == "_") begin
      foreach (lx_word[i]) lx_word[i] = 8'h00;
      lx_wlen = 0;
      append_word(c);
      open_token(c, M_WORD);
    end else if (is_num(c)) begin
      open_token(c, M_INT);
    end else begin
      case (c)
        "-": open_token(c, M_SIGN);
        "'": open_token(c, M_STR);
        "!": open_token(c, M_BANG);
        "<": open_token(c, M_LT);
        ">": open_token(c, M_GT);
        "(": begin open_token(c, M_IDLE); close_token(TK_LPAREN); end
        ")": begin open_token(c, M_IDLE); close_token(TK_RPAREN); end
        ",": begin open_token(c, M_IDLE); close_token(TK_COMMA); end
        ";": begin open_token(c, M_IDLE); close_token(TK_SEMI); end
        "*": begin open_token(c, M_IDLE); close_token(TK_STAR); end
        "=": begin open_token(c, M_IDLE); close_token(TK_EQ); end
        default: begin
          lx_org_off = lx_off;
          lx_org_line = lx_line;
          lx_org_col = lx_col;
          lx_span = 0;
          raise_error(ERR_CHAR);
        end
      endcase
    end
  endfunction

  // Returns 0 when the byte ended the pending token and has to be scanned again.
  function automatic bit scan_byte(byte unsigned c);
    case (lx_mode)
      M_IDLE: scan_from_idle(c);
      M_WORD: begin
        if (is_letter(c) || is_num(c) || c == "_") begin
          append_word(c);
          consume(c);
        end else begin
          close_token(classify_word());
          return 1'b0;
        end
      end
      M_SIGN: begin
        if (is_num(c)) begin
          consume(c);
          lx_mode = M_INT;
        end else raise_error(ERR_CHAR);
      end
      M_INT: begin
        if (is_num(c)) consume(c);
        else if (c == ".") begin
          consume(c);
          lx_mode = M_DOT;
        end else begin
          close_token(TK_INT);
          return 1'b0;
        end
      end
      M_DOT: begin
        if (is_num(c)) begin
          consume(c);
          lx_mode = M_FRAC;
        end else raise_error(ERR_NUMBER);
      end
      M_FRAC: begin
        if (is_num(c)) consume(c);
        else begin
          close_token(TK_DOUBLE);
          return 1'b0;
        end
      end
      M_STR: begin
        consume(c);
        if (c == "'") lx_mode = M_STRQ;
      end
      M_STRQ: begin
        if (c == "'") begin
          consume(c);
          lx_mode = M_STR;
        end else begin
          close_token(TK_STRING);
          return 1'b0;
        end
      end
      M_BANG: begin
        if (c == "=") begin
          consume(c);
          close_token(TK_NE);
        end else raise_error(ERR_BANG);
      end
      M_LT, M_GT: begin
        if (c == "=") begin
          consume(c);
          close_token(lx_mode == M_LT ? TK_LE : TK_GE);
        end else begin
          close_token(lx_mode == M_LT ? TK_LT : TK_GT);
          return 1'b0;
        end
      end
      default: begin
        lx_mode = M_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // Works out the tokens that one accepted request gives.
  function automatic void predict_tokens(byte unsigned c, bit pres, bit eoi);
    lx_nres = 0;
    if (pres && !lx_hold) begin
      if (!scan_byte(c) && !lx_hold) void'(scan_byte(c));
    end
    if (eoi) begin
      if (!lx_hold) begin
        case (lx_mode)
          M_WORD: close_token(classify_word());
          M_SIGN: raise_error(ERR_CHAR);
          M_INT: close_token(TK_INT);
          M_DOT: raise_error(ERR_NUMBER);
          M_FRAC: close_token(TK_DOUBLE);
          M_STR: raise_error(ERR_STRING);
          M_STRQ: close_token(TK_STRING);
          M_BANG: raise_error(ERR_BANG);
          M_LT: close_token(TK_LT);
          M_GT: close_token(TK_GT);
          default: ;
        endcase
      end
      if (!lx_hold) begin
        lx_org_off = lx_off;
        lx_org_line = lx_line;
        lx_org_col = lx_col;
        emit_token(TK_EOF, ERR_NONE, 0);
      end
      lexer_clear();
    end
    if (lx_nres > 0) pending_tokens[pending_tokens.size()-1].last = 1'b1;
  endfunction

  function automatic void note_mismatch(string what, token_t want, token_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected %p, got %p", what, want, got);
  endfunction

  // Result check against the oldest expected token.
  always @(posedge clk) begin
    token_t got;
    got = '{kind: token_kind, code: error_code, off: start_offset, line: start_line,
            col: start_column, span: span_length, last: last_of_run};
    if (!rst && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) note_mismatch("unexpected token", '0, got);
      else if (pending_tokens[0] !== got) note_mismatch("token", pending_tokens[0], got);
      if (pending_tokens.size() != 0) void'(pending_tokens.pop_front());
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("[sql_token_scanner] ERROR");
      $finish;
    end
  end

  // The receiver stalls on a rotating pattern, sometimes always ready.
  always @(negedge clk) begin
    static int cyc = 0;
    static logic [31:0] stall_pattern = '1;
    if (cyc % 96 == 0)
      stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'h1);
    out_ready <= stall_pattern[cyc % 32];
    cyc++;
  end

  // Sends one request; called at a falling edge and returns at one.
  task automatic send_request(byte unsigned c, bit pres, bit eoi);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    character <= c;
    char_present <= pres;
    end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    predict_tokens(c, pres, eoi);
    if (pres) bytes_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Hold off the sender until every expected token has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(negedge clk);
  endtask

  function automatic void add_row(byte unsigned c, bit pres, bit eoi, bit typed = 0,
                                  logic [5:0] kind = TK_EOF, logic [2:0] code = ERR_NONE,
                                  int off = 0, int line = 1, int col = 1, int span = 0);
    row_t r;
    r.ch = c;
    r.pres = pres;
    r.eoi = eoi;
    r.typed = typed;
    r.want = '{kind: kind, code: code, off: 16'(off), line: 16'(line), col: 16'(col),
               span: 16'(span), last: 1'b0};
    rows.insert(rows.size(), r);
  endfunction

  function automatic void add_byte(byte unsigned b);
    stmt.insert(stmt.size(), b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic byte unsigned rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // One random token, mostly well formed.
  function automatic void add_random_token();
    string ops[5] = '{"<", "<=", ">", ">=", "!="};
    string puncts = "(),;*=";
    string broken[4] = '{"!", "-", "1.", "'"};
    string idchars = "abcxyzQRS_0123456789";
    string kw;
    int pick;
    pick = $urandom_range(0, 12);
    if (pick >= 9) pick = $urandom_range(0, 6);
    case (pick)
      0: begin
        kw = keywords[$urandom_range(0, 28)];
        for (int i = 0; i < kw.len(); i++)
          add_byte((is_letter(kw[i]) && $urandom_range(0, 1)) ? kw[i] + 8'd32 : kw[i]);
      end
      1: begin
        add_byte($urandom_range(0, 4) == 0 ? "_" : 8'("a" + $urandom_range(0, 25)));
        repeat ($urandom_range(0, 9)) add_byte(idchars[$urandom_range(0, 19)]);
      end
      2: begin
        if ($urandom_range(0, 2) == 0) add_byte("-");
        repeat ($urandom_range(1, 4)) add_byte(rand_digit());
      end
      3: begin
        repeat ($urandom_range(1, 3)) add_byte(rand_digit());
        add_byte(".");
        repeat ($urandom_range(1, 3)) add_byte(rand_digit());
      end
      4: begin
        add_byte("'");
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 4) == 0) add_text("''");
          else add_byte(8'($urandom_range(32, 126) == 39 ? 65 : $urandom_range(32, 126)));
        end
        add_byte("'");
      end
      5: add_byte(puncts[$urandom_range(0, 5)]);
      6: add_text(ops[$urandom_range(0, 4)]);
      7: add_byte(8'($urandom_range(0, 255)));
      default: add_text(broken[$urandom_range(0, 3)]);
    endcase
  endfunction

  task automatic send_statement();
    string spaces = " \t\n\r";
    stmt.delete();
    repeat ($urandom_range(1, 8)) begin
      add_random_token();
      if ($urandom_range(0, 1)) add_byte(spaces[$urandom_range(0, 3)]);
    end
    foreach (stmt[i]) begin
      if ($urandom_range(0, 15) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(stmt[i], 1'b1, (i == stmt.size() - 1) && stmt.size() % 2 == 0);
    end
    if (stmt.size() % 2 == 1) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    lexer_clear();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests: special cases from reset, each statement ended.
    add_row(8'h00, 0, 1, 1, TK_EOF, ERR_NONE, 0, 1, 1, 0);
    add_row(8'h00, 1, 0, 1, TK_ERROR, ERR_CHAR, 0, 1, 1, 0);
    add_row("a", 1, 0);
    add_row(8'h00, 0, 1);
    add_row("a", 1, 0);
    add_row("<", 1, 0);
    add_row("b", 1, 1);
    add_row("!", 1, 0);
    add_row("x", 1, 1, 1, TK_ERROR, ERR_BANG, 0, 1, 1, 0);
    add_row("-", 1, 1, 1, TK_ERROR, ERR_CHAR, 0, 1, 1, 0);
    add_row("7", 1, 0);
    add_row(".", 1, 0);
    add_row(8'h00, 0, 1, 1, TK_ERROR, ERR_NUMBER, 0, 1, 1, 0);
    add_row("'", 1, 0);
    add_row("a", 1, 0);
    add_row(8'hff, 0, 1, 1, TK_ERROR, ERR_STRING, 0, 1, 1, 0);
    add_row(8'hff, 1, 1, 1, TK_ERROR, ERR_CHAR, 0, 1, 1, 0);
    add_row("=", 1, 1, 1, TK_EQ, ERR_NONE, 0, 1, 1, 1);
    add_row(">", 1, 0);
    add_row("=", 1, 1, 1, TK_GE, ERR_NONE, 0, 1, 1, 2);
    add_row(8'ha5, 0, 0);
    add_row(8'h0a, 1, 0);
    add_row("x", 1, 1);
    foreach (rows[i]) begin
      send_request(rows[i].ch, rows[i].pres, rows[i].eoi);
      if (rows[i].typed) begin
        token_t seen;
        seen = lx_first;
        seen.last = 1'b0;
        if (lx_nres == 0 || seen !== rows[i].want)
          note_mismatch("directed request", rows[i].want, seen);
      end
    end
    drain_results();

    // Random statements, with quiet stretches and occasional full drains.
    while (bytes_sent < 360) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      send_statement();
      if ($urandom_range(0, 9) == 0) drain_results();
    end
    in_valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("[sql_token_scanner] OK");
    else $display("[sql_token_scanner] ERROR");
    $finish;
  end

endmodule
